// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every edge including reset.
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/btc_pkg.sv =====
`default_nettype none
package btc_pkg;

   // Field widths.
   localparam int RAW_W   = 24;
   localparam int COEFF_W = 16;
   localparam int TEMP_W  = 19;
   localparam int PRES_W  = 32;
   localparam int DT_W    = 25;
   localparam int PROD_W  = 42;
   localparam int OFF_W   = 37;
   localparam int SENS_W  = 36;
   localparam int SPLIT_W = 18;
   localparam int PPLO_W  = RAW_W + SPLIT_W;
   localparam int PPHI_W  = RAW_W + 1 + SENS_W - SPLIT_W;
   localparam int FULL_W  = 61;
   localparam int DIFF_W  = 41;
   localparam int CSR_IDX_W = 3;

   // Base temperature of 20.00 degrees, in centidegrees, added to the scaled delta.
   localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

   // Register indexes of the coefficient bank.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRES_SENS   = 3'd0,
      CSR_PRES_OFF    = 3'd1,
      CSR_SENS_TCOEF  = 3'd2,
      CSR_OFF_TCOEF   = 3'd3,
      CSR_TEMP_REF    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COEFF_W-1:0] pres_sens;
      logic [COEFF_W-1:0] pres_off;
      logic [COEFF_W-1:0] sens_tcoef;
      logic [COEFF_W-1:0] off_tcoef;
      logic [COEFF_W-1:0] temp_ref;
      logic [COEFF_W-1:0] temp_slope;
   } coeff_set_type;

   // Intermediate values handed from the temperature unit to the pressure unit.
   typedef struct packed {
      logic [RAW_W-1:0]         raw_pressure;
      logic signed [TEMP_W-1:0] temp;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
   } mid_type;

endpackage
`default_nettype wire

// ===== rtl/btc_req_if.sv =====
`default_nettype none
interface btc_req_if import btc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_pressure;
   logic [RAW_W-1:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface
`default_nettype wire

// ===== rtl/btc_rsp_if.sv =====
`default_nettype none
interface btc_rsp_if import btc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centideg;
   logic signed [PRES_W-1:0] pressure_pascal;

   modport source (output valid, output temperature_centideg, output pressure_pascal,
                   input ready);
   modport sink   (input valid, input temperature_centideg, input pressure_pascal,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/btc_coeff_regs.sv =====
`default_nettype none
module btc_coeff_regs import btc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEFF_W-1:0]   csr_wdata,
   output coeff_set_type             coeff
);

   coeff_set_type coeff_ff;
   coeff_set_type coeff_in;

   // Decode the register index; writes beyond the bank are dropped.
   always_comb begin
      coeff_in = coeff_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PRES_SENS:  coeff_in.pres_sens  = csr_wdata;
            CSR_PRES_OFF:   coeff_in.pres_off   = csr_wdata;
            CSR_SENS_TCOEF: coeff_in.sens_tcoef = csr_wdata;
            CSR_OFF_TCOEF:  coeff_in.off_tcoef  = csr_wdata;
            CSR_TEMP_REF:   coeff_in.temp_ref   = csr_wdata;
            CSR_TEMP_SLOPE: coeff_in.temp_slope = csr_wdata;
            default:        coeff_in = coeff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   assign coeff = coeff_ff;

endmodule
`default_nettype wire

// ===== rtl/btc_temp_unit.sv =====
`default_nettype none
// Three stages: temperature difference, three coefficient products, then
// temperature, offset and sensitivity.
module btc_temp_unit import btc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire coeff_set_type    coeff,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [RAW_W-1:0] in_raw_pressure,
   input  wire logic [RAW_W-1:0] in_raw_temperature,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output mid_type               out_data
);

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;

   logic [RAW_W-1:0]         d1_s1_ff, d1_s2_ff;
   logic signed [DT_W-1:0]   dt_ff, dt_in;
   logic signed [PROD_W-1:0] prod_t_ff, prod_o_ff, prod_s_ff;
   logic signed [PROD_W-1:0] prod_t_in, prod_o_in, prod_s_in;
   mid_type                  mid_ff, mid_in;

   // A stage may load when it is empty or its content moves on.
   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage 1: raw temperature minus the reference temperature.
   assign dt_in = signed'({1'b0, in_raw_temperature})
                  - signed'({1'b0, coeff.temp_ref, 8'd0});

   // Stage 2: the three products of the temperature difference.
   assign prod_t_in = dt_ff * signed'({1'b0, coeff.temp_slope});
   assign prod_o_in = dt_ff * signed'({1'b0, coeff.off_tcoef});
   assign prod_s_in = dt_ff * signed'({1'b0, coeff.sens_tcoef});

   // Stage 3: scale the products and add the base terms.
   always_comb begin
      mid_in.raw_pressure = d1_s2_ff;
      mid_in.temp = signed'(prod_t_ff[PROD_W-1:23]) + TEMP_BASE;
      mid_in.off  = signed'({4'd0, coeff.pres_off, 17'd0})
                    + signed'({prod_o_ff[PROD_W-1], prod_o_ff[PROD_W-1:6]});
      mid_in.sens = signed'({4'd0, coeff.pres_sens, 16'd0})
                    + signed'({prod_s_ff[PROD_W-1], prod_s_ff[PROD_W-1:7]});
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         d1_s1_ff <= in_raw_pressure;
         dt_ff    <= dt_in;
      end
      if (rdy2) begin
         d1_s2_ff  <= d1_s1_ff;
         prod_t_ff <= prod_t_in;
         prod_o_ff <= prod_o_in;
         prod_s_ff <= prod_s_in;
      end
      if (rdy3) begin
         mid_ff <= mid_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = mid_ff;

endmodule
`default_nettype wire

// ===== rtl/btc_pres_unit.sv =====
`default_nettype none
// Three stages: split pressure product, its recombination, then offset
// subtraction and final scaling.
module btc_pres_unit import btc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire mid_type             in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic signed [TEMP_W-1:0] out_temp,
   output logic signed [PRES_W-1:0] out_pres
);

   logic v4_ff, v5_ff, v6_ff;
   logic v4_in, v5_in, v6_in;
   logic rdy4, rdy5, rdy6;

   logic [PPLO_W-1:0]         pp_lo_ff, pp_lo_in;
   logic signed [PPHI_W-1:0]  pp_hi_ff, pp_hi_in;
   logic signed [FULL_W-1:0]  full_ff, full_in;
   logic signed [OFF_W-1:0]   off_s4_ff, off_s5_ff;
   logic signed [TEMP_W-1:0]  temp_s4_ff, temp_s5_ff, temp_s6_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PRES_W-1:0]  pres_ff, pres_in;

   // A stage may load when it is empty or its content moves on.
   assign rdy6 = !v6_ff || out_ready;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign in_ready = rdy4;

   assign v4_in = rdy4 ? in_valid : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;
   assign v6_in = rdy6 ? v5_ff : v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   // Stage 4: raw pressure times sensitivity, as low and high partial products.
   assign pp_lo_in = in_data.raw_pressure * in_data.sens[SPLIT_W-1:0];
   assign pp_hi_in = signed'({1'b0, in_data.raw_pressure})
                     * signed'(in_data.sens[SENS_W-1:SPLIT_W]);

   // Stage 5: recombine the partial products.
   assign full_in = signed'({pp_hi_ff[FULL_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}})
                    + signed'({{(FULL_W-PPLO_W){1'b0}}, pp_lo_ff});

   // Stage 6: scale down, subtract the offset and scale again.
   assign diff = signed'({full_ff[FULL_W-1], full_ff[FULL_W-1:21]})
                 - signed'({{(DIFF_W-OFF_W){off_s5_ff[OFF_W-1]}}, off_s5_ff});
   assign pres_in = signed'({{6{diff[DIFF_W-1]}}, diff[DIFF_W-1:15]});

   always_ff @(posedge clock) begin
      if (rdy4) begin
         pp_lo_ff   <= pp_lo_in;
         pp_hi_ff   <= pp_hi_in;
         off_s4_ff  <= in_data.off;
         temp_s4_ff <= in_data.temp;
      end
      if (rdy5) begin
         full_ff    <= full_in;
         off_s5_ff  <= off_s4_ff;
         temp_s5_ff <= temp_s4_ff;
      end
      if (rdy6) begin
         pres_ff    <= pres_in;
         temp_s6_ff <= temp_s5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign out_temp  = temp_s6_ff;
   assign out_pres  = pres_ff;

endmodule
`default_nettype wire

// ===== rtl/baro_temp_compensation_core.sv =====
// An accepted request passes through pipeline stages 1 to 6 in order on its way to the result.
// Throughput: one request per cycle while the output is not stalled, set by the six-stage multiply and add pipeline.
// A stalled result holds in the last stage while earlier empty stages keep filling.
// Reset (synchronous) clears all stage valid bits and sets every coefficient to zero.
`default_nettype none
`include "assert_macros.svh"
module baro_temp_compensation_core import btc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   btc_req_if.sink                   req,
   btc_rsp_if.source                 rsp,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEFF_W-1:0]   csr_wdata
);

   coeff_set_type coeff;
   mid_type       mid_data;
   logic          mid_valid;
   logic          mid_ready;

   // Calibration coefficient bank.
   btc_coeff_regs u_coeff_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coeff        (coeff)
   );

   // Temperature, offset and sensitivity.
   btc_temp_unit u_temp_unit (
      .clock              (clock),
      .reset              (reset),
      .coeff              (coeff),
      .in_valid           (req.valid),
      .in_ready           (req.ready),
      .in_raw_pressure    (req.raw_pressure),
      .in_raw_temperature (req.raw_temperature),
      .out_valid          (mid_valid),
      .out_ready          (mid_ready),
      .out_data           (mid_data)
   );

   // Compensated pressure.
   btc_pres_unit u_pres_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_temp  (rsp.temperature_centideg),
      .out_pres  (rsp.pressure_pascal)
   );

   // The input side only stalls when a finished result is waiting.
   `ASSERT_IMPLIES(a_stall_source, clock, reset, !req.ready, rsp.valid && !rsp.ready)
   // Nothing is presented right after reset.
   `ASSERT_NEXT(a_reset_empty, clock, reset, !rsp.valid && !mid_valid)
   // A held request between the two units keeps its contents.
   `ASSERT_NEXT(a_mid_hold, clock, !reset && mid_valid && !mid_ready,
                reset || (mid_valid && $stable(mid_data)))

endmodule
`default_nettype wire

// ===== test/baro_temp_compensation_core_test.sv =====
`timescale 1ns / 1ps
module baro_temp_compensation_core_test;
   import btc_pkg::*;

   localparam int HALF_PERIOD     = 2;
   localparam int NUM_COEFFS      = 6;
   localparam int RAW_MAX         = (1 << RAW_W) - 1;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int SQUEEZE_PHASE   = 4;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int TAIL_CYCLES     = 24;
   localparam int PRINT_CAP       = 40;
   localparam int PROBE_ROWS      = 18;
   localparam longint TEMP_BASE_CENTIDEG = 2000;

   // The two unused slots of the register index space.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Coefficient banks used by the directed part.
   localparam logic [2:0] BANK_RESET       = 3'd0;
   localparam logic [2:0] BANK_OFFSET_ONLY = 3'd1;
   localparam logic [2:0] BANK_ALL_ONES    = 3'd2;
   localparam logic [2:0] BANK_TYPICAL     = 3'd3;
   localparam logic [2:0] BANK_COLD_LIMIT  = 3'd4;

   typedef logic [COEFF_W-1:0] coeff_bank_type [NUM_COEFFS];

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic signed [PRES_W-1:0] pressure;
   } reading_type;

   typedef struct packed {
      logic [2:0]               bank;
      logic [RAW_W-1:0]         raw_pressure;
      logic [RAW_W-1:0]         raw_temperature;
      logic                     literal;
      logic signed [TEMP_W-1:0] temperature;
      logic signed [PRES_W-1:0] pressure;
   } probe_row_type;

   // Bank order: sensitivity, offset, sensitivity drift, offset drift, reference, slope.
   coeff_bank_type probe_banks [5] = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
      '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}
   };

   // Rows with the literal flag carry their own expectation; the rest use the predictor.
   probe_row_type probe_rows [PROBE_ROWS] = '{
      // Reset coefficients: temperature sits at the base, pressure at zero.
      '{BANK_RESET, 24'h000000, 24'h000000, 1'b1, 19'sd2000, 32'sd0},
      '{BANK_RESET, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'sd2000, 32'sd0},
      '{BANK_RESET, 24'h800000, 24'h7FFFFF, 1'b1, 19'sd2000, 32'sd0},
      // Only the base offset at its maximum: pressure is minus four times it.
      '{BANK_OFFSET_ONLY, 24'h000000, 24'h000000, 1'b1, 19'sd2000, -32'sd262140},
      '{BANK_OFFSET_ONLY, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'sd2000, -32'sd262140},
      // All coefficients at their maximum, including zero and minus one delta.
      '{BANK_ALL_ONES, 24'h000000, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{BANK_ALL_ONES, 24'hFFFFFF, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{BANK_ALL_ONES, 24'h000000, 24'hFFFFFF, 1'b0, 19'sd0, 32'sd0},
      '{BANK_ALL_ONES, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 32'sd0},
      '{BANK_ALL_ONES, 24'h800000, 24'hFFFF00, 1'b0, 19'sd0, 32'sd0},
      '{BANK_ALL_ONES, 24'hFFFFFF, 24'hFFFEFF, 1'b0, 19'sd0, 32'sd0},
      // Typical factory coefficients around the reference temperature.
      '{BANK_TYPICAL, 24'd6465444, 24'd8077636, 1'b0, 19'sd0, 32'sd0},
      '{BANK_TYPICAL, 24'd6465444, 24'd8077568, 1'b0, 19'sd0, 32'sd0},
      '{BANK_TYPICAL, 24'd6465444, 24'd8077567, 1'b0, 19'sd0, 32'sd0},
      '{BANK_TYPICAL, 24'h000000, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      // Large drift terms, at the most negative and the most positive temperature delta of this bank.
      '{BANK_COLD_LIMIT, 24'hFFFFFF, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{BANK_COLD_LIMIT, 24'h000001, 24'h000000, 1'b0, 19'sd0, 32'sd0},
      '{BANK_COLD_LIMIT, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 32'sd0}
   };

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [COEFF_W-1:0]   csr_wdata    = '0;

   btc_req_if req_if ();
   btc_rsp_if rsp_if ();

   coeff_bank_type coeff_mirror = '{default: '0};
   reading_type    expected_readings [$];
   bit             calm             = 1'b0;
   bit             hold_off_pending = 1'b0;
   int unsigned    mismatches       = 0;
   int unsigned    requests_sent    = 0;
   int unsigned    results_checked  = 0;
   int unsigned    banks_loaded     = 0;

   always #(HALF_PERIOD) clock = ~clock;

   baro_temp_compensation_core dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // First-order compensation of one reading pair with the current coefficients.
   function automatic reading_type compensate(input logic [RAW_W-1:0] raw_p,
                                              input logic [RAW_W-1:0] raw_t);
      longint      d1, d2, sens_c, off_c, tcs, tco, tref, slope;
      longint      dt, temp, off, sens, pres;
      reading_type r;
      d1     = raw_p;
      d2     = raw_t;
      sens_c = coeff_mirror[CSR_PRES_SENS];
      off_c  = coeff_mirror[CSR_PRES_OFF];
      tcs    = coeff_mirror[CSR_SENS_TCOEF];
      tco    = coeff_mirror[CSR_OFF_TCOEF];
      tref   = coeff_mirror[CSR_TEMP_REF];
      slope  = coeff_mirror[CSR_TEMP_SLOPE];
      dt     = d2 - (tref <<< 8);
      temp   = TEMP_BASE_CENTIDEG + ((dt * slope) >>> 23);
      off    = (off_c <<< 17) + ((dt * tco) >>> 6);
      sens   = (sens_c <<< 16) + ((tcs * dt) >>> 7);
      pres   = (((d1 * sens) >>> 21) - off) >>> 15;
      r.temperature = temp[TEMP_W-1:0];
      r.pressure    = pres[PRES_W-1:0];
      return r;
   endfunction

   task automatic log_mismatch(input string detail);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, detail);
      end
   endtask

   // One register write; the caller lowers the write enable after the last one.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [COEFF_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      if (idx < NUM_COEFFS) begin
         coeff_mirror[idx] = value;
      end
      @(negedge clock);
   endtask

   // Loads a full bank, then pokes the unused indexes, which must change nothing.
   task automatic load_coefficients(input coeff_bank_type bank);
      foreach (bank[i]) begin
         write_register(csr_index_type'(i), bank[i]);
      end
      write_register(CSR_SPARE_LO, COEFF_W'($urandom));
      write_register(CSR_SPARE_HI, COEFF_W'($urandom));
      csr_write_en <= 1'b0;
      banks_loaded++;
   endtask

   // Stops offering requests and waits until every result has come back.
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Offers one request after a random gap (none in calm phases); returns at the falling edge after acceptance.
   task automatic send_reading_pair(input logic [RAW_W-1:0] raw_p,
                                    input logic [RAW_W-1:0] raw_t, input reading_type want);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.raw_pressure    <= raw_p;
      req_if.raw_temperature <= raw_t;
      do @(posedge clock); while (!req_if.ready);
      expected_readings.push_back(want);
      requests_sent++;
      @(negedge clock);
   endtask

   // Result side: random stalls per result outside calm phases, plus one long hold-off on request.
   initial begin : result_receiver
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_pending) begin
            stall            = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end else begin
            stall = calm ? 0 : $urandom_range(0, 19);
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      reading_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_readings.size() == 0) begin
            log_mismatch($sformatf("unexpected result %0d / %0d",
                                   rsp_if.temperature_centideg, rsp_if.pressure_pascal));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_if.temperature_centideg !== want.temperature) begin
               log_mismatch($sformatf("result %0d temperature_centideg %0d, expected %0d",
                                      results_checked, rsp_if.temperature_centideg,
                                      want.temperature));
            end
            if (rsp_if.pressure_pascal !== want.pressure) begin
               log_mismatch($sformatf("result %0d pressure_pascal %0d, expected %0d",
                                      results_checked, rsp_if.pressure_pascal,
                                      want.pressure));
            end
            results_checked++;
         end
      end
   end

   // Ends the run when neither channel has moved for too long.
   initial begin : stall_watch
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Watchdog: no request or result moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      logic [2:0]       current_bank;
      coeff_bank_type   bank;
      reading_type      want;
      logic [RAW_W-1:0] raw_p, raw_t;
      int               near;
      req_if.valid           <= 1'b0;
      req_if.raw_pressure    <= '0;
      req_if.raw_temperature <= '0;
      rsp_if.ready           <= 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed corner cases, one coefficient bank after another.
      current_bank = BANK_RESET;
      foreach (probe_rows[i]) begin
         if (probe_rows[i].bank != current_bank) begin
            drain_pipeline();
            current_bank = probe_rows[i].bank;
            load_coefficients(probe_banks[current_bank]);
         end
         if (probe_rows[i].literal) begin
            want.temperature = probe_rows[i].temperature;
            want.pressure    = probe_rows[i].pressure;
         end else begin
            want = compensate(probe_rows[i].raw_pressure, probe_rows[i].raw_temperature);
         end
         send_reading_pair(probe_rows[i].raw_pressure, probe_rows[i].raw_temperature, want);
      end

      // Random phases, each under a fresh bank that often hits the register extremes.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pipeline();
         foreach (bank[i]) begin
            case ($urandom_range(0, 3))
               0: begin
                  bank[i] = '0;
               end
               1: begin
                  bank[i] = '1;
               end
               default: begin
                  bank[i] = COEFF_W'($urandom);
               end
            endcase
         end
         load_coefficients(bank);
         calm = (phase % 3 == 1);
         if (phase == SQUEEZE_PHASE) begin
            // Back-to-back requests against a long output stall fill the pipeline.
            calm             = 1'b1;
            hold_off_pending = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) begin
            case ($urandom_range(0, 7))
               0: begin
                  raw_p = '0;
               end
               1: begin
                  raw_p = '1;
               end
               default: begin
                  raw_p = RAW_W'($urandom);
               end
            endcase
            case ($urandom_range(0, 7))
               0: begin
                  raw_t = '0;
               end
               1: begin
                  raw_t = '1;
               end
               2, 3: begin
                  // Close to the reference point, so the delta changes sign often.
                  near = int'({coeff_mirror[CSR_TEMP_REF], 8'h00})
                         + int'($urandom_range(0, 1024)) - 512;
                  if (near < 0) begin
                     near = 0;
                  end else if (near > RAW_MAX) begin
                     near = RAW_MAX;
                  end
                  raw_t = near[RAW_W-1:0];
               end
               default: begin
                  raw_t = RAW_W'($urandom);
               end
            endcase
            send_reading_pair(raw_p, raw_t, compensate(raw_p, raw_t));
         end
      end

      drain_pipeline();
      calm = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d reading pairs under %0d coefficient banks, %0d results checked.",
               requests_sent, banks_loaded, results_checked);
      $display("Covered register and input extremes, sign changes of the temperature delta,");
      $display("idle and back-to-back traffic, and one long output stall.");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
